// ===== rtl/bitmap_id_allocator_macros.svh =====
`ifndef BITMAP_ID_ALLOCATOR_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BIA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bitmap_id_allocator check failed");

// Next-cycle implication, sampled on clk_i, off during reset.
`define BIA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bitmap_id_allocator check failed");

`endif

// ===== rtl/bia_pkg.sv =====
`default_nettype none

package bia_pkg;

  localparam int unsigned BASE_ID   = 300;
  localparam int unsigned NUM_IDS   = 4096;
  localparam int unsigned ID_W      = 13;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned BIT_W     = 6;
  localparam int unsigned NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int unsigned WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned SEQ_W     = $clog2(NUM_WORDS + 2);
  localparam int unsigned LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_W;
  localparam logic [WORD_W-1:0] TAIL_MASK =
      (LAST_BITS == WORD_W) ? {WORD_W{1'b1}} : ((WORD_W'(1) << LAST_BITS) - WORD_W'(1));

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ALLOC    = 2'd0,
    ST_FULL     = 2'd1,
    ST_RELEASED = 2'd2,
    ST_IGNORED  = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [ID_W-1:0] id_in;
  } bia_req_t;

  typedef struct packed {
    status_e         status;
    logic [ID_W-1:0] id_out;
  } bia_rsp_t;

  typedef struct packed {
    logic load_req;
    logic scan_init;
    logic scan_rd;
    logic scan_eval;
    logic rel_rd;
    logic rel_eval;
    logic set_full;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic is_release;
    logic pool_full;
    logic hit;
    logic exhausted;
    logic iss_done;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/bia_ctrl.sv =====
`default_nettype none

module bia_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire              out_ready_i,
  input  bia_pkg::dp_sts_t sts_i,
  output bia_pkg::dp_cmd_t cmd_o
);
  import bia_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL_RD,
    S_REL_EV,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          if (sts_i.is_release) begin
            state_d = S_REL_RD;
          end else if (sts_i.pool_full) begin
            cmd_o.set_full = 1'b1;
            state_d        = S_COMMIT;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
        end
      end
      S_REL_RD: begin
        cmd_o.rel_rd = 1'b1;
        state_d      = S_REL_EV;
      end
      S_REL_EV: begin
        cmd_o.rel_eval = 1'b1;
        state_d        = S_COMMIT;
      end
      S_SCAN: begin
        cmd_o.scan_rd   = !sts_i.iss_done;
        cmd_o.scan_eval = 1'b1;
        if (sts_i.hit || sts_i.exhausted) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (slot_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bia_datapath.sv =====
`default_nettype none

module bia_datapath (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  bia_pkg::bia_req_t in_req_i,
  input  bia_pkg::dp_cmd_t cmd_i,
  output bia_pkg::dp_sts_t sts_o,
  output bia_pkg::bia_rsp_t out_rsp_o
);
  import bia_pkg::*;

  // first set bit, two levels of eight
  function automatic logic [BIT_W:0] find_first(input logic [WORD_W-1:0] v);
    logic [7:0] grp_any;
    logic [7:0] grp_bits;
    logic [2:0] g;
    logic [2:0] b;
    g = '0;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      grp_any[i] = |v[i*8 +: 8];
    end
    for (int i = 7; i >= 0; i--) begin
      if (grp_any[i]) begin
        g = 3'(i);
      end
    end
    grp_bits = v[g*8 +: 8];
    for (int i = 7; i >= 0; i--) begin
      if (grp_bits[i]) begin
        b = 3'(i);
      end
    end
    return {|grp_any, g, b};
  endfunction

  logic [WORD_W-1:0]  mem [NUM_WORDS];
  logic [WORD_W-1:0]  mem_rdata_q;
  logic [NUM_WORDS-1:0] row_valid_q;
  logic               rv_q;
  logic               dvalid_q;
  logic [WADDR_W-1:0] rd_word_q;
  logic [SEQ_W-1:0]   rd_seq_q;

  bia_req_t           req_q;
  logic [POS_W-1:0]   pos_q;
  logic [CNT_W-1:0]   count_q;
  logic [WADDR_W-1:0] scan_addr_q;
  logic [SEQ_W-1:0]   iss_cnt_q;
  logic [BIT_W-1:0]   start_bit_q;

  status_e            res_q;
  logic [WORD_W-1:0]  hit_word_q;
  logic [WADDR_W-1:0] hit_addr_q;
  logic [POS_W-1:0]   hit_pos_q;
  bia_rsp_t           out_q;

  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic [ID_W:0]      rel_diff;
  logic               in_range;
  logic [POS_W-1:0]   rel_pos;
  logic [WADDR_W-1:0] rel_addr;
  logic [BIT_W-1:0]   rel_bit;
  logic [WORD_W-1:0]  word;
  logic [WORD_W-1:0]  free_bits;
  logic [BIT_W:0]     ff;
  logic [POS_W-1:0]   pos_eff;
  logic               wr_en;

  assign rel_diff = {1'b0, req_q.id_in} - (ID_W+1)'(BASE_ID);
  assign in_range = !rel_diff[ID_W] && (rel_diff < (ID_W+1)'(NUM_IDS));
  assign rel_pos  = rel_diff[POS_W-1:0];
  assign rel_addr = rel_pos[BIT_W +: WADDR_W];
  assign rel_bit  = rel_pos[BIT_W-1:0];

  assign rd_en   = cmd_i.scan_rd || cmd_i.rel_rd;
  assign rd_addr = cmd_i.rel_rd ? rel_addr : scan_addr_q;

  assign word      = rv_q ? mem_rdata_q : '0;
  assign free_bits = ~word
                   & ((rd_word_q == WADDR_W'(NUM_WORDS - 1)) ? TAIL_MASK : {WORD_W{1'b1}})
                   & ((rd_seq_q == '0) ? ({WORD_W{1'b1}} << start_bit_q) : {WORD_W{1'b1}});
  assign ff        = find_first(free_bits);

  assign pos_eff = ({1'b0, pos_q} >= CNT_W'(NUM_IDS)) ? '0 : pos_q;
  assign wr_en   = cmd_i.commit && (res_q == ST_ALLOC || res_q == ST_RELEASED);

  assign sts_o.is_release = (in_req_i.cmd == CMD_RELEASE);
  assign sts_o.pool_full  = (count_q >= CNT_W'(NUM_IDS));
  assign sts_o.hit        = dvalid_q && ff[BIT_W];
  assign sts_o.exhausted  = dvalid_q && !ff[BIT_W] && (rd_seq_q == SEQ_W'(NUM_WORDS));
  assign sts_o.iss_done   = (iss_cnt_q == SEQ_W'(NUM_WORDS + 1));

  assign out_rsp_o = out_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[hit_addr_q] <= hit_word_q;
    end
    if (rd_en) begin
      mem_rdata_q <= mem[rd_addr];
      rd_word_q   <= rd_addr;
      rd_seq_q    <= iss_cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rv_q        <= 1'b0;
      dvalid_q    <= 1'b0;
      pos_q       <= '0;
      count_q     <= '0;
    end else begin
      dvalid_q <= rd_en;
      if (rd_en) begin
        rv_q <= row_valid_q[rd_addr];
      end
      if (wr_en) begin
        row_valid_q[hit_addr_q] <= 1'b1;
      end
      if (cmd_i.commit && res_q == ST_ALLOC) begin
        count_q <= count_q + CNT_W'(1);
        pos_q   <= hit_pos_q;
      end else if (cmd_i.commit && res_q == ST_RELEASED && count_q != '0) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.scan_init) begin
      scan_addr_q <= pos_eff[BIT_W +: WADDR_W];
      start_bit_q <= pos_eff[BIT_W-1:0];
      iss_cnt_q   <= '0;
    end else if (cmd_i.scan_rd) begin
      scan_addr_q <= (scan_addr_q == WADDR_W'(NUM_WORDS - 1)) ? '0
                                                              : scan_addr_q + WADDR_W'(1);
      iss_cnt_q   <= iss_cnt_q + SEQ_W'(1);
    end
    if (cmd_i.set_full) begin
      res_q <= ST_FULL;
    end else if (cmd_i.scan_eval && sts_o.hit) begin
      res_q      <= ST_ALLOC;
      hit_word_q <= word | (WORD_W'(1) << ff[BIT_W-1:0]);
      hit_addr_q <= rd_word_q;
      hit_pos_q  <= POS_W'({rd_word_q, ff[BIT_W-1:0]});
    end else if (cmd_i.scan_eval && sts_o.exhausted) begin
      res_q <= ST_FULL;
    end else if (cmd_i.rel_eval) begin
      res_q      <= (in_range && word[rel_bit]) ? ST_RELEASED : ST_IGNORED;
      hit_word_q <= word & ~(WORD_W'(1) << rel_bit);
      hit_addr_q <= rel_addr;
    end
    if (cmd_i.commit) begin
      out_q.status <= res_q;
      unique case (res_q)
        ST_ALLOC:    out_q.id_out <= ID_W'(BASE_ID) + ID_W'(hit_pos_q);
        ST_FULL:     out_q.id_out <= '0;
        ST_RELEASED: out_q.id_out <= req_q.id_in;
        ST_IGNORED:  out_q.id_out <= req_q.id_in;
        default:     out_q.id_out <= '0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bitmap_id_allocator.sv =====
`default_nettype none

// Next-fit id allocator over a bitmap of NUM_IDS ids from BASE_ID, held as
// 64-bit words in one internal memory with a valid bit per word, so the pool is
// empty right after reset with no clearing pass. One request is worked at a
// time. A release reads the word of its id and then clears the bit if it is set. An
// allocate reads one word per cycle from the kept search position, wrapping
// at the top, through the single memory read port. A full pool answers
// without a search. The result sits in an output register, and a new request
// is accepted while it waits.
module bitmap_id_allocator (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  bia_pkg::bia_req_t in_req_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output bia_pkg::bia_rsp_t out_rsp_o
);
  import bia_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bia_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bia_checker.sv =====
`default_nettype none

`include "bitmap_id_allocator_macros.svh"

module bia_sva (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_ready_o,
  input bia_pkg::bia_req_t in_req_i,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input bia_pkg::bia_rsp_t out_rsp_o
);
  import bia_pkg::*;

  `BIA_ASSERT_NEXT(a_in_hold, in_valid_i && !in_ready_o, in_valid_i && $stable(in_req_i))
  `BIA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_rsp_o))
  `BIA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `BIA_ASSERT_NOW(a_alloc_range, out_valid_o && out_rsp_o.status == ST_ALLOC, out_rsp_o.id_out >= ID_W'(BASE_ID) && out_rsp_o.id_out <= ID_W'(BASE_ID + NUM_IDS - 1))
  `BIA_ASSERT_NOW(a_full_zero, out_valid_o && out_rsp_o.status == ST_FULL, out_rsp_o.id_out == '0)

endmodule

bind bitmap_id_allocator bia_sva u_bia_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// ===== sim/bia_checker.sv =====
`timescale 1ns / 1ps

module bia_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_ready_i,
  input  bia_pkg::bia_req_t req_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  bia_pkg::bia_rsp_t rsp_i,
  output int unsigned       fail_cnt_o,
  output int unsigned       pending_o
);
  import bia_pkg::*;

  bit               taken [NUM_IDS];
  logic [CNT_W-1:0] taken_cnt = '0;
  logic [POS_W-1:0] next_pos = '0;
  bia_rsp_t         owed_answers [$];

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("%0t: %s got %0d, expected %0d", $time, what, got, want);
    fail_cnt_o++;
  endtask

  function automatic bia_rsp_t pool_answer(bia_req_t r);
    bia_rsp_t    ans;
    int unsigned pos;
    int unsigned slot;
    bit          found;
    ans.status = ST_FULL;
    ans.id_out = '0;
    found = 1'b0;
    pos = next_pos;
    if (r.cmd == CMD_ALLOC) begin
      if (pos >= NUM_IDS) pos = 0;
      if (taken_cnt < NUM_IDS) begin
        for (int n = 0; n < NUM_IDS && !found; n++) begin
          if (!taken[pos]) found = 1'b1;
          else pos = (pos + 1 >= NUM_IDS) ? 0 : pos + 1;
        end
      end
      if (found) begin
        taken[pos] = 1'b1;
        taken_cnt = taken_cnt + 1'b1;
        next_pos = POS_W'(pos);
        ans.status = ST_ALLOC;
        ans.id_out = ID_W'(BASE_ID + pos);
      end
    end else begin
      slot = r.id_in - BASE_ID;
      ans.id_out = r.id_in;
      if (r.id_in >= BASE_ID && slot < NUM_IDS && taken[slot]) begin
        taken[slot] = 1'b0;
        if (taken_cnt != 0) taken_cnt = taken_cnt - 1'b1;
        ans.status = ST_RELEASED;
      end else begin
        ans.status = ST_IGNORED;
      end
    end
    return ans;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bia_rsp_t want;
    if (!rst_ni) begin
      foreach (taken[i]) taken[i] = 1'b0;
      taken_cnt = '0;
      next_pos = '0;
      owed_answers.delete();
      pending_o = 0;
    end else begin
      if (rsp_valid_i === 1'b1 && rsp_ready_i) begin
        if (owed_answers.size() == 0) begin
          flag_mismatch("response with no request outstanding, status", rsp_i.status, 0);
        end else begin
          want = owed_answers.pop_front();
          if (rsp_i.status !== want.status)
            flag_mismatch("status", rsp_i.status, want.status);
          if (rsp_i.id_out !== want.id_out)
            flag_mismatch("id_out", rsp_i.id_out, want.id_out);
        end
      end
      if (req_valid_i && req_ready_i === 1'b1)
        owed_answers.push_back(pool_answer(req_i));
      pending_o = owed_answers.size();
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import bia_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     out_ready_i = 1'b0;
  bia_req_t in_req_i = '0;
  logic     in_ready_o;
  logic     out_valid_o;
  bia_rsp_t out_rsp_o;

  int unsigned fail_cnt;
  int unsigned pending;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_cycles = 0;
  bit          full_seen = 1'b0;

  logic [ID_W-1:0] held_ids [$];
  logic [ID_W-1:0] last_freed = ID_W'(BASE_ID);

  always #1 clk_i = ~clk_i;

  bitmap_id_allocator DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  bia_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_valid_i),
    .req_ready_i(in_ready_o),
    .req_i      (in_req_i),
    .rsp_valid_i(out_valid_o),
    .rsp_ready_i(out_ready_i),
    .rsp_i      (out_rsp_o),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending)
  );

  // track granted ids so releases can target live ones
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_ready_i) begin
      if (out_rsp_o.status == ST_ALLOC) held_ids.push_back(out_rsp_o.id_out);
      if (out_rsp_o.status == ST_FULL) full_seen = 1'b1;
    end
  end

  initial begin
    int unsigned hold;
    bit          hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0 && !hold_done) begin
        hold = hold_cycles;
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic push_req(input cmd_e cmd, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= '{cmd: cmd, id_in: id};
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
  endtask

  task automatic free_held();
    int unsigned idx;
    idx = $urandom_range(held_ids.size() - 1);
    last_freed = held_ids[idx];
    held_ids.delete(idx);
    push_req(CMD_RELEASE, last_freed);
  endtask

  task automatic random_mix(input int unsigned count, input int unsigned alloc_pct);
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < alloc_pct)
        push_req(CMD_ALLOC, ID_W'($urandom));
      else if (pick < alloc_pct + 30 && held_ids.size() != 0)
        free_held();
      else if (pick < alloc_pct + 38)
        push_req(CMD_RELEASE, ID_W'($urandom_range(BASE_ID + NUM_IDS - 1, BASE_ID)));
      else if (pick < alloc_pct + 44)
        push_req(CMD_RELEASE, last_freed);
      else
        push_req(CMD_RELEASE, ID_W'($urandom));
    end
  endtask

  initial begin
    int unsigned src_pct [4] = '{0, 66, 0, 8};
    int unsigned sink_pct [4] = '{0, 0, 66, 8};
    int unsigned guard;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '1);
    push_req(CMD_RELEASE, ID_W'(BASE_ID));
    push_req(CMD_RELEASE, ID_W'(BASE_ID));
    push_req(CMD_RELEASE, ID_W'(BASE_ID - 1));
    push_req(CMD_RELEASE, ID_W'(BASE_ID + NUM_IDS));
    push_req(CMD_RELEASE, ID_W'(BASE_ID + NUM_IDS - 1));
    push_req(CMD_RELEASE, '0);
    push_req(CMD_RELEASE, '1);
    push_req(CMD_ALLOC, ID_W'(BASE_ID));
    push_req(CMD_RELEASE, ID_W'(BASE_ID + 1));
    push_req(CMD_ALLOC, '0);
    push_req(CMD_ALLOC, '0);
    push_req(CMD_RELEASE, ID_W'(BASE_ID + 2));
    push_req(CMD_RELEASE, ID_W'(BASE_ID + 3));
    push_req(CMD_ALLOC, '1);

    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = src_pct[ph];
      sink_stall_pct = sink_pct[ph];
      if (ph == 0) hold_cycles = 300;
      random_mix(400, 50);
    end

    // grow the pool with a run of allocations, then probe it a few more times
    src_idle_pct = 0;
    sink_stall_pct = 0;
    guard = 0;
    while (!full_seen && guard < 200) begin
      push_req(CMD_ALLOC, ID_W'($urandom));
      guard++;
    end
    repeat (4) push_req(CMD_ALLOC, ID_W'($urandom));

    // churn the pool with mixed allocate and release traffic
    src_idle_pct = 8;
    sink_stall_pct = 8;
    repeat (43) begin
      if (held_ids.size() != 0) free_held();
      push_req(CMD_ALLOC, ID_W'($urandom));
      push_req(($urandom_range(1) == 0) ? CMD_ALLOC : CMD_RELEASE, ID_W'($urandom));
    end

    in_valid_i <= 1'b0;
    sink_stall_pct = 0;
    @(posedge clk_i);
    guard = 0;
    while (pending != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
